/* hw/rtl/pearson_correlation_macros.svh */
// Assertion macros used by the block's controller.
`ifndef PEARSON_CORRELATION_MACROS_SVH
`define PEARSON_CORRELATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pc_pkg.sv */
package pc_pkg;

  localparam int MAX_PAIRS   = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = 17;
  localparam int MUL_A_W     = 128;
  localparam int MUL_B_W     = 64;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_VAR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE = 4'd0,
    OP_NSXX = 4'd1,
    OP_SX2  = 4'd2,
    OP_NSYY = 4'd3,
    OP_SY2  = 4'd4,
    OP_NSXY = 4'd5,
    OP_SXSY = 4'd6,
    OP_VXY  = 4'd7,
    OP_NUM2 = 4'd8,
    OP_TSQ  = 4'd9,
    OP_TV   = 4'd10
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accum;
    logic mul_start;
    logic post;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic overflow;
    logic zero_var;
    logic loop_done;
  } stat_t;

endpackage

/* hw/rtl/pc_mul.sv */
module pc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pc_pkg::MUL_A_W-1:0]  a,
  input  logic [pc_pkg::MUL_B_W-1:0]  b,
  output logic                        done,
  output logic [pc_pkg::MUL_P_W-1:0]  product
);

  logic [pc_pkg::MUL_P_W-1:0] ma;
  logic [pc_pkg::MUL_B_W-1:0] mb;
  logic                       running;

  assign done = running && (mb == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
    end else if (done) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma      <= pc_pkg::MUL_P_W'(a);
      mb      <= b;
      product <= '0;
    end else if (running && (mb != '0)) begin
      if (mb[0]) begin
        product <= product + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule

/* hw/rtl/pc_dp.sv */
module pc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [15:0]                x_sample,
  input  logic signed [15:0]                y_sample,
  input  pc_pkg::cmd_t                      cmd,
  output pc_pkg::stat_t                     stat,
  output logic signed [15:0]                correlation,
  output logic [1:0]                        status,
  output logic [pc_pkg::COUNT_W-1:0]        pair_count
);

  logic signed [pc_pkg::SAMPLE_BITS-1:0]   xv, yv;
  logic signed [2*pc_pkg::SAMPLE_BITS-1:0] xx, yy, xy;

  logic [pc_pkg::COUNT_W-1:0] n;
  logic signed [32:0]         sx, sy;
  logic [46:0]                sxx, syy;
  logic signed [47:0]         sxy;
  logic                       ovf;

  logic [63:0]  t0, vx, vy, mag;
  logic         t0_neg, num_neg;
  logic [127:0] vv, rr;
  logic [33:0]  tsq;
  logic [16:0]  q;
  logic [4:0]   bitpos;
  logic         loop_done;

  logic [32:0]  sx_abs, sy_abs;
  logic [47:0]  sxy_abs;
  logic [16:0]  t;
  logic [pc_pkg::MUL_A_W-1:0] mul_a;
  logic [pc_pkg::MUL_B_W-1:0] mul_b;
  logic [pc_pkg::MUL_P_W-1:0] p;
  logic         mul_done;
  logic signed [65:0] sa, sb, num;
  logic [16:0]  qn, qp;
  logic [16:0]  qneg;
  logic [1:0]   res_status;
  logic signed [15:0] res_corr;

  assign xv = x_sample[pc_pkg::SAMPLE_BITS-1:0];
  assign yv = y_sample[pc_pkg::SAMPLE_BITS-1:0];
  assign xx = xv * xv;
  assign yy = yv * yv;
  assign xy = xv * yv;

  assign sx_abs  = sx[32]  ? 33'(-sx)  : 33'(sx);
  assign sy_abs  = sy[32]  ? 33'(-sy)  : 33'(sy);
  assign sxy_abs = sxy[47] ? 48'(-sxy) : 48'(sxy);
  assign t       = q | (17'd1 << bitpos);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pc_pkg::OP_NSXX: begin
        mul_a = pc_pkg::MUL_A_W'(n);
        mul_b = pc_pkg::MUL_B_W'(sxx);
      end
      pc_pkg::OP_SX2: begin
        mul_a = pc_pkg::MUL_A_W'(sx_abs);
        mul_b = pc_pkg::MUL_B_W'(sx_abs);
      end
      pc_pkg::OP_NSYY: begin
        mul_a = pc_pkg::MUL_A_W'(n);
        mul_b = pc_pkg::MUL_B_W'(syy);
      end
      pc_pkg::OP_SY2: begin
        mul_a = pc_pkg::MUL_A_W'(sy_abs);
        mul_b = pc_pkg::MUL_B_W'(sy_abs);
      end
      pc_pkg::OP_NSXY: begin
        mul_a = pc_pkg::MUL_A_W'(n);
        mul_b = pc_pkg::MUL_B_W'(sxy_abs);
      end
      pc_pkg::OP_SXSY: begin
        mul_a = pc_pkg::MUL_A_W'(sx_abs);
        mul_b = pc_pkg::MUL_B_W'(sy_abs);
      end
      pc_pkg::OP_VXY: begin
        mul_a = pc_pkg::MUL_A_W'(vx);
        mul_b = vy;
      end
      pc_pkg::OP_NUM2: begin
        mul_a = pc_pkg::MUL_A_W'(mag);
        mul_b = mag;
      end
      pc_pkg::OP_TSQ: begin
        mul_a = pc_pkg::MUL_A_W'(t);
        mul_b = pc_pkg::MUL_B_W'(t);
      end
      pc_pkg::OP_TV: begin
        mul_a = vv;
        mul_b = pc_pkg::MUL_B_W'(tsq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (p)
  );

  assign sa  = t0_neg ? -66'(t0) : 66'(t0);
  assign sb  = (sx[32] ^ sy[32]) ? -66'(p[63:0]) : 66'(p[63:0]);
  assign num = sa - sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      sx  <= '0;
      sy  <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
      ovf <= 1'b0;
    end else if (cmd.load_out) begin
      n   <= '0;
      sx  <= '0;
      sy  <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
      ovf <= 1'b0;
    end else if (cmd.accum) begin
      if (n < pc_pkg::COUNT_W'(pc_pkg::MAX_PAIRS)) begin
        n   <= n + 1'b1;
        sx  <= sx + 33'(xv);
        sy  <= sy + 33'(yv);
        sxx <= sxx + 47'($unsigned(xx));
        syy <= syy + 47'($unsigned(yy));
        sxy <= sxy + 48'(xy);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      unique case (cmd.op)
        pc_pkg::OP_NSXX, pc_pkg::OP_NSYY: t0 <= p[63:0];
        pc_pkg::OP_SX2:  vx <= t0 - p[63:0];
        pc_pkg::OP_SY2:  vy <= t0 - p[63:0];
        pc_pkg::OP_NSXY: begin
          t0     <= p[63:0];
          t0_neg <= sxy[47];
        end
        pc_pkg::OP_SXSY: begin
          num_neg <= num[65];
          mag     <= num[65] ? 64'(-num) : 64'(num);
        end
        pc_pkg::OP_VXY:  vv <= p[127:0];
        pc_pkg::OP_NUM2: begin
          rr        <= p[127:0];
          q         <= '0;
          bitpos    <= 5'd16;
          loop_done <= 1'b0;
        end
        pc_pkg::OP_TSQ:  tsq <= p[33:0];
        pc_pkg::OP_TV: begin
          if (p <= pc_pkg::MUL_P_W'({rr, 30'd0})) begin
            q <= t;
          end
          if (bitpos == '0) begin
            loop_done <= 1'b1;
          end else begin
            bitpos <= bitpos - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.mul_done  = mul_done;
  assign stat.overflow  = ovf;
  assign stat.zero_var  = (vx == '0) || (vy == '0);
  assign stat.loop_done = loop_done;

  assign qn   = (q > 17'd32768) ? 17'd32768 : q;
  assign qp   = (q > 17'd32767) ? 17'd32767 : q;
  assign qneg = 17'd0 - qn;

  always_comb begin
    if (ovf) begin
      res_status = pc_pkg::ST_OVERFLOW;
    end else if (stat.zero_var) begin
      res_status = pc_pkg::ST_ZERO_VAR;
    end else begin
      res_status = pc_pkg::ST_OK;
    end
  end

  assign res_corr = (res_status != pc_pkg::ST_OK) ? 16'sd0 :
                    num_neg ? $signed(qneg[15:0]) : $signed(qp[15:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      correlation <= res_corr;
      status      <= res_status;
      pair_count  <= ovf ? pc_pkg::COUNT_W'(pc_pkg::MAX_PAIRS) : n;
    end
  end

endmodule

/* hw/rtl/pc_ctrl.sv */
`include "pearson_correlation_macros.svh"

module pc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_pair,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  pc_pkg::stat_t stat,
  output pc_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_ACCUM  = 6'b000001,
    S_DECIDE = 6'b000010,
    S_START  = 6'b000100,
    S_RUN    = 6'b001000,
    S_POST   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t        state, state_next;
  pc_pkg::op_t   op, op_next;
  logic          accept;
  logic          out_free;

  assign in_stall = (state != S_ACCUM);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_ACCUM: begin
        if (accept && last_pair) begin
          state_next = S_DECIDE;
          op_next    = pc_pkg::OP_IDLE;
        end
      end
      S_DECIDE: begin
        state_next = S_START;
        unique case (op)
          pc_pkg::OP_IDLE: begin
            if (stat.overflow) begin
              state_next = S_DONE;
            end else begin
              op_next = pc_pkg::OP_NSXX;
            end
          end
          pc_pkg::OP_NSXX: op_next = pc_pkg::OP_SX2;
          pc_pkg::OP_SX2:  op_next = pc_pkg::OP_NSYY;
          pc_pkg::OP_NSYY: op_next = pc_pkg::OP_SY2;
          pc_pkg::OP_SY2: begin
            if (stat.zero_var) begin
              state_next = S_DONE;
            end else begin
              op_next = pc_pkg::OP_NSXY;
            end
          end
          pc_pkg::OP_NSXY: op_next = pc_pkg::OP_SXSY;
          pc_pkg::OP_SXSY: op_next = pc_pkg::OP_VXY;
          pc_pkg::OP_VXY:  op_next = pc_pkg::OP_NUM2;
          pc_pkg::OP_NUM2: op_next = pc_pkg::OP_TSQ;
          pc_pkg::OP_TSQ:  op_next = pc_pkg::OP_TV;
          pc_pkg::OP_TV: begin
            if (stat.loop_done) begin
              state_next = S_DONE;
            end else begin
              op_next = pc_pkg::OP_TSQ;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_START: state_next = S_RUN;
      S_RUN: begin
        if (stat.mul_done) begin
          state_next = S_POST;
        end
      end
      S_POST: state_next = S_DECIDE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_ACCUM;
        end
      end
      default: state_next = S_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      op        <= pc_pkg::OP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cmd.op        = op;
  assign cmd.accum     = accept;
  assign cmd.mul_start = (state == S_START);
  assign cmd.post      = (state == S_POST);
  assign cmd.load_out  = (state == S_DONE) && out_free;

  `PC_ASSERT_NEXT(a_last_goes_decide, accept && last_pair, state == S_DECIDE)
  `PC_ASSERT_SAME(a_mul_done_in_run, stat.mul_done, state == S_RUN)
  `PC_ASSERT_SAME(a_load_when_free, cmd.load_out, !out_valid || !out_stall)

endmodule

/* hw/rtl/pearson_correlation.sv */
// Pearson correlation of sets of signed (x, y) sample pairs.
// Input channel: in_valid/in_stall with x_sample, y_sample and last_pair.
// A pair is taken on each cycle in which in_valid is high and in_stall low;
// while a set is being gathered in_stall stays low, so one pair can be accumulated every cycle.
// A transfer with last_pair high closes the set. The block then raises
// in_stall while it forms r with a bit-serial shift-add multiplier that
// retires one multiplier bit per cycle: eight wide products and a 17-step
// compare loop of two products each; an error status cuts this short.
// The result (correlation in Q1.15, status, pair_count) is then written to
// an output register and offered on out_valid/out_stall. If the receiver
// stalls, the result holds and a later result waits until it is taken;
// pairs of the next set are accepted while an earlier result still waits.
// Status 1 flags zero variance, status 2 more pairs than the maximum.
// Synchronous reset clears the running sums, the count and out_valid.
module pearson_correlation (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          x_sample,
  input  logic signed [15:0]          y_sample,
  input  logic                        last_pair,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          correlation,
  output logic [1:0]                  status,
  output logic [pc_pkg::COUNT_W-1:0]  pair_count
);

  pc_pkg::cmd_t  cmd;
  pc_pkg::stat_t stat;

  pc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_pair (last_pair),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .cmd         (cmd),
    .stat        (stat),
    .correlation (correlation),
    .status      (status),
    .pair_count  (pair_count)
  );

endmodule

/* bench/tb_pearson_correlation.sv */
module tb_pearson_correlation;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0]           corr;
    logic [1:0]                   stat;
    logic [pc_pkg::COUNT_W-1:0]   count;
  } corr_result_t;

  typedef struct {
    logic signed [15:0]           x;
    logic signed [15:0]           y;
    logic                         last;
    logic                         typed;
    logic signed [15:0]           corr;
    logic [1:0]                   stat;
    logic [pc_pkg::COUNT_W-1:0]   count;
  } pair_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [15:0]         x_sample = '0;
  logic signed [15:0]         y_sample = '0;
  logic                       last_pair = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [15:0]         correlation;
  logic [1:0]                 status;
  logic [pc_pkg::COUNT_W-1:0] pair_count;

  logic                       row_typed = 1'b0;
  corr_result_t               row_result = '{16'sd0, pc_pkg::ST_OK, '0};
  logic                       quiet = 1'b0;
  int                         stall_left = 0;
  int                         errors = 0;

  corr_result_t               expected_results[$];

  longint                     n_pairs;
  longint                     acc_x, acc_y, acc_xy;
  longint                     acc_xx, acc_yy;
  bit                         too_many;

  pearson_correlation i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .last_pair   (last_pair),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .correlation (correlation),
    .status      (status),
    .pair_count  (pair_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic corr_result_t correlate_set();
    corr_result_t res;
    longint vx, vy, num, mag;
    logic [191:0] vprod, rhs, lhs;
    logic [16:0] q, t;
    res.corr = '0;
    res.stat = pc_pkg::ST_OK;
    res.count = n_pairs[pc_pkg::COUNT_W-1:0];
    if (too_many) begin
      res.stat = pc_pkg::ST_OVERFLOW;
      res.count = pc_pkg::COUNT_W'(pc_pkg::MAX_PAIRS);
      return res;
    end
    vx = n_pairs * acc_xx - acc_x * acc_x;
    vy = n_pairs * acc_yy - acc_y * acc_y;
    if (vx == 0 || vy == 0) begin
      res.stat = pc_pkg::ST_ZERO_VAR;
      return res;
    end
    num = n_pairs * acc_xy - acc_x * acc_y;
    mag = (num < 0) ? -num : num;
    vprod = 192'(vx) * 192'(vy);
    rhs = (192'(mag) * 192'(mag)) << 30;
    q = '0;
    for (int b = 16; b >= 0; b--) begin
      t = q | (17'd1 << b);
      lhs = 192'(t) * 192'(t) * vprod;
      if (lhs <= rhs) q = t;
    end
    if (num < 0) begin
      if (q > 17'd32768) q = 17'd32768;
      res.corr = 16'(-$signed({1'b0, q}));
    end else begin
      if (q > 17'd32767) q = 17'd32767;
      res.corr = $signed(q[15:0]);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    corr_result_t res;
    longint xv, yv;
    if (rst) begin
      n_pairs = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
      too_many = 0;
    end else if (in_valid && !in_stall) begin
      xv = x_sample;
      yv = y_sample;
      if (n_pairs < pc_pkg::MAX_PAIRS) begin
        n_pairs++;
        acc_x += xv; acc_y += yv; acc_xy += xv * yv;
        acc_xx += xv * xv; acc_yy += yv * yv;
      end else begin
        too_many = 1;
      end
      if (last_pair) begin
        res = correlate_set();
        expected_results.push_back(row_typed ? row_result : res);
        n_pairs = 0; acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
        too_many = 0;
      end
    end
  end

  always @(posedge clk) begin
    corr_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result corr %0d status %0d count %0d",
                 $time, correlation, status, pair_count);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (correlation !== exp_r.corr) begin
          $display("%0t: correlation expected %0d actual %0d", $time, exp_r.corr, correlation);
          errors++;
        end
        if (status !== exp_r.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.stat, status);
          errors++;
        end
        if (pair_count !== exp_r.count) begin
          $display("%0t: pair_count expected %0d actual %0d", $time, exp_r.count, pair_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pair(input pair_row_t row, input bit gaps);
    if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    x_sample   <= row.x;
    y_sample   <= row.y;
    last_pair  <= row.last;
    row_typed  <= row.typed;
    row_result <= '{row.corr, row.stat, row.count};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic pair_row_t plain_row(input logic signed [15:0] x,
                                          input logic signed [15:0] y, input logic last);
    return '{x, y, last, 1'b0, 16'sd0, pc_pkg::ST_OK, '0};
  endfunction

  pair_row_t directed [18];

  initial begin
    int set_len, mode, budget;
    bit paused;
    logic signed [15:0] x, y, noise;

    paused = 1'b0;
    directed = '{
      '{-16'sd32768, 16'sd32767, 1'b1, 1'b1, 16'sd0, pc_pkg::ST_ZERO_VAR, 17'd1},
      '{16'sd1, 16'sd1, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd2, 16'sd2, 1'b1, 1'b1, 16'sd32767, pc_pkg::ST_OK, 17'd2},
      '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd32767, -16'sd32768, 1'b1, 1'b1, -16'sd32768, pc_pkg::ST_OK, 17'd2},
      '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, 16'sd32767, pc_pkg::ST_OK, 17'd2},
      '{16'sd1, 16'sd5, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd2, 16'sd5, 1'b1, 1'b1, 16'sd0, pc_pkg::ST_ZERO_VAR, 17'd2},
      '{16'sd7, -16'sd3, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd7, 16'sd9, 1'b1, 1'b1, 16'sd0, pc_pkg::ST_ZERO_VAR, 17'd2},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd1, 16'sd3, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd2, -16'sd4, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{-16'sd5, 16'sd1, 1'b1, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd100, 16'sd200, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{-16'sd300, 16'sd250, 1'b0, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0},
      '{16'sd12345, -16'sd4321, 1'b1, 1'b0, 16'sd0, pc_pkg::ST_OK, 17'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_pair(directed[i], 1'b1);

    budget = 1100;
    while (budget > 0) begin
      if (budget < 150) quiet <= 1'b1;
      if (!paused && budget < 600) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
                                            : $urandom_range(1, 12);
      mode = $urandom_range(0, 4);
      for (int k = 0; k < set_len; k++) begin
        x = 16'($urandom_range(0, 65535));
        noise = $signed(16'($urandom_range(0, 63))) - 16'sd32;
        case (mode)
          0: y = 16'($urandom_range(0, 65535));
          1: begin
            x = $signed(16'($urandom_range(0, 255))) - 16'sd128;
            y = $signed(16'($urandom_range(0, 255))) - 16'sd128;
          end
          2: y = (x >>> 1) + noise;
          3: y = -(x >>> 2) + noise;
          default: x = 16'sd77;
        endcase
        send_pair(plain_row(x, y, k == set_len - 1), 1'b1);
        budget--;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
